[hw/rtl/its_pkg.sv]
// ----------------------------------------------------------------------------
// its_pkg: shared types and constants
// Item layouts, operation codes and widths for the interval timer block.
// ----------------------------------------------------------------------------
package its_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int ID_W = 4;
	localparam int STAMP_W = 63;
	localparam int SUM_W = 64;
	localparam int CNT_W = 32;
	localparam int DEV_W = 32;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_STOP   = 2'd1,
		OP_REPORT = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [ID_W-1:0]    timer_id;
		logic [STAMP_W-1:0] timestamp_ns;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    report_id;
		logic [CNT_W-1:0]   sample_count;
		logic [STAMP_W-1:0] mean_ns;
		logic [DEV_W-1:0]   deviation_ns;
		logic [STAMP_W-1:0] longest_ns;
	} out_item_t;

	// Item handed from the front part to the back part
	typedef struct packed {
		logic [1:0]         operation;
		logic [ID_W-1:0]    timer_id;
		logic [STAMP_W-1:0] timestamp_ns;
	} cmd_t;

endpackage

[hw/rtl/interval_timer_statistics.sv]
// ----------------------------------------------------------------------------
// interval_timer_statistics: timer table with running statistics
// Start, stop, clear and report on a table of interval timers.
// ----------------------------------------------------------------------------
// Start and clear act in the idle state; stop passes the square and sum states.
// A report holds the back part through 64-step divides of the sum of
// squares and of the sum, then a 32-step square root, in one shared unit.
// A two-entry queue sits before the back part; busy rises when it is full.
// Reset clears all timers at once; the receiver cannot stall the strobe.
module interval_timer_statistics import its_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  in_item,
	output logic      busy,
	output logic      strobe,
	output out_item_t result
);

	logic cmd_valid, cmd_take;
	cmd_t cmd;

	its_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.busy(busy), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	its_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .result_valid(strobe), .result(result)
	);

endmodule

[hw/rtl/its_front.sv]
// ----------------------------------------------------------------------------
// its_front: command intake
// Accepts items, drops out-of-range timer indices, queues the rest.
// ----------------------------------------------------------------------------
module its_front import its_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t in_item,
	output logic     busy,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_take
);

	localparam int QD = 2;

	cmd_t       q_mem_q [QD];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       push, in_range;

	// classify: only in-range timers go on
	assign in_range = ({1'b0, in_item.timer_id} < (ID_W+1)'(NUM_TIMERS));
	assign busy = (fill_q == 2'(QD));
	assign push = start && !busy && in_range;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd = q_mem_q[rd_ptr_q];

	// hold queued items
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_t'(in_item);
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_take) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(cmd_take);
		end
	end

endmodule

[hw/rtl/its_divsqrt.sv]
// ----------------------------------------------------------------------------
// its_divsqrt: iterative arithmetic
// 64/32 restoring divide and 64-bit floor square root, one bit a cycle.
// ----------------------------------------------------------------------------
module its_divsqrt import its_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             is_sqrt,
	input  logic [SUM_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	output logic             done,
	output logic [SUM_W-1:0] res
);

	logic             run_q, sq_q;
	logic [6:0]       step_q;
	logic [SUM_W-1:0] quo_q;
	logic [SUM_W:0]   rem_q;
	logic [CNT_W-1:0] den_q;
	logic [SUM_W-1:0] v_q, root_q, bit_q;
	logic [SUM_W:0]   rem_sh, rem_sub;
	logic [SUM_W-1:0] trial;

	assign rem_sh  = {rem_q[SUM_W-1:0], quo_q[SUM_W-1]};
	assign rem_sub = rem_sh - {33'd0, den_q};
	assign trial   = root_q + bit_q;
	assign res     = sq_q ? root_q : quo_q;

	// iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			sq_q <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				sq_q <= is_sqrt;
				step_q <= is_sqrt ? 7'd32 : 7'd64;
			end else if (run_q) begin
				step_q <= step_q - 7'd1;
				if (step_q == 7'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
			v_q <= num;
			root_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (sq_q) begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				if (!rem_sub[SUM_W]) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
			end
		end
	end

endmodule

[hw/rtl/its_back.sv]
// ----------------------------------------------------------------------------
// its_back: command execution
// Applies start, stop and clear to the timer table and works out reports.
// ----------------------------------------------------------------------------
module its_back import its_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_take,
	output logic      result_valid,
	output out_item_t result
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SQR  = 9'b000000010,
		ST_ACC  = 9'b000000100,
		ST_DIVS = 9'b000001000,
		ST_WTS  = 9'b000010000,
		ST_DIVE = 9'b000100000,
		ST_WTE  = 9'b001000000,
		ST_MSQ  = 9'b010000000,
		ST_SQRT = 9'b100000000
	} state_t;

	state_t state_q;

	logic [STAMP_W-1:0] stamp_q [NUM_TIMERS];
	logic [SUM_W-1:0]   esum_q  [NUM_TIMERS];
	logic [SUM_W-1:0]   ssum_q  [NUM_TIMERS];
	logic [STAMP_W-1:0] long_q  [NUM_TIMERS];
	logic [CNT_W-1:0]   cnt_q   [NUM_TIMERS];

	cmd_t               cur_q;
	logic [IW-1:0]      idx;
	logic [STAMP_W-1:0] el_q;
	logic [SUM_W-1:0]   sq_s1;
	logic [SUM_W-1:0]   qsq_q, mean_q, m2_q;
	logic               dgo, dsqrt, ddone;
	logic [SUM_W-1:0]   dnum, dres;
	logic [STAMP_W-1:0] mean_sat;
	logic [SUM_W-1:0]   var_v;

	assign idx = cur_q.timer_id[IW-1:0];
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;
	assign mean_sat = mean_q[SUM_W-1] ? {STAMP_W{1'b1}} : mean_q[STAMP_W-1:0];
	assign var_v = (mean_q[SUM_W-1:CNT_W] == '0 && qsq_q > m2_q) ? qsq_q - m2_q : '0;

	// select divider operands
	always_comb begin
		dgo = 1'b0;
		dsqrt = 1'b0;
		dnum = ssum_q[idx];
		case (state_q)
			ST_DIVS: begin
				dgo = 1'b1;
			end
			ST_DIVE: begin
				dgo = 1'b1;
				dnum = esum_q[idx];
			end
			ST_MSQ: begin
				dgo = 1'b1;
				dsqrt = 1'b1;
				dnum = var_v;
			end
			default: begin
			end
		endcase
	end

	its_divsqrt u_ds (
		.clk(clk), .arst_n(arst_n), .go(dgo), .is_sqrt(dsqrt),
		.num(dnum), .den(cnt_q[idx]), .done(ddone), .res(dres)
	);

	// sequence each command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				stamp_q[i] <= '0;
				esum_q[i] <= '0;
				ssum_q[i] <= '0;
				long_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (op_t'(cmd.operation))
							OP_START: begin
								if (cnt_q[cmd.timer_id[IW-1:0]] != '1)
									cnt_q[cmd.timer_id[IW-1:0]] <=
										cnt_q[cmd.timer_id[IW-1:0]] + 1'b1;
								stamp_q[cmd.timer_id[IW-1:0]] <= cmd.timestamp_ns;
							end
							OP_STOP: state_q <= ST_SQR;
							OP_CLEAR: begin
								stamp_q[cmd.timer_id[IW-1:0]] <= '0;
								esum_q[cmd.timer_id[IW-1:0]] <= '0;
								ssum_q[cmd.timer_id[IW-1:0]] <= '0;
								long_q[cmd.timer_id[IW-1:0]] <= '0;
								cnt_q[cmd.timer_id[IW-1:0]] <= '0;
							end
							OP_REPORT: state_q <= ST_DIVS;
							default: begin
							end
						endcase
					end
				end
				ST_SQR: state_q <= ST_ACC;
				ST_ACC: begin
					esum_q[idx] <= esum_q[idx] + {1'b0, el_q};
					ssum_q[idx] <= ssum_q[idx] + sq_s1;
					if (el_q > long_q[idx]) long_q[idx] <= el_q;
					state_q <= ST_IDLE;
				end
				ST_DIVS: state_q <= ST_WTS;
				ST_WTS: if (ddone) state_q <= ST_DIVE;
				ST_DIVE: state_q <= ST_WTE;
				ST_WTE: if (ddone) state_q <= ST_MSQ;
				ST_MSQ: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (ddone) begin
						result_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold command, elapsed time, square and report terms
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q <= cmd;
			el_q <= (cmd.timestamp_ns >= stamp_q[cmd.timer_id[IW-1:0]]) ?
				cmd.timestamp_ns - stamp_q[cmd.timer_id[IW-1:0]] : '0;
		end
		// square modulo 2^64 from 32-bit partial products
		if (state_q == ST_SQR) begin
			sq_s1 <= (64'(el_q[31:0]) * 64'(el_q[31:0])) +
				({32'(el_q[31:0] * el_q[62:32]), 32'd0} << 1);
		end
		if (state_q == ST_WTS && ddone) qsq_q <= dres;
		// latch the mean and its square as the divide ends
		if (state_q == ST_WTE && ddone) begin
			mean_q <= dres;
			m2_q <= 64'(dres[31:0]) * 64'(dres[31:0]);
		end
		if (state_q == ST_SQRT && ddone) begin
			result.report_id <= cur_q.timer_id;
			result.sample_count <= cnt_q[idx];
			result.mean_ns <= (cnt_q[idx] == '0) ? '0 : mean_sat;
			result.deviation_ns <= (cnt_q[idx] == '0) ? '0 : dres[DEV_W-1:0];
			result.longest_ns <= long_q[idx];
		end
	end

endmodule

[hw/rtl/its_checker.sv]
// ----------------------------------------------------------------------------
// its_checker: port-level checks
// Watches the top level's ports for strobe, report value and busy slips.
// ----------------------------------------------------------------------------
module its_checker import its_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      strobe,
	input out_item_t result
);

	// a report strobe is a pulse, never held high
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("strobe held");

	// zero count gives zero mean and deviation
	a_zero_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.sample_count == '0 |->
		result.mean_ns == '0 && result.deviation_ns == '0)
		else $error("zero count stats");

	// busy rises only after a start
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without item");

endmodule

bind interval_timer_statistics its_checker u_chk (.*);
